[sv/wmpa_pkg.sv]
// wmpa_pkg: shared constants, codes and transaction types for the windowed max-plus argmax block
// depends on nothing; used by wmpa_acc, windowed_max_plus_argmax and the testbench
package wmpa_pkg;

  // grid and window limits
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_RADIUS = 7;

  localparam int WIN_SIDE  = 2 * MAX_RADIUS + 1;
  localparam int MSG_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int WGT_DEPTH = WIN_SIDE * WIN_SIDE;
  localparam int MSG_AW    = $clog2(MSG_DEPTH);
  localparam int WGT_AW    = $clog2(WGT_DEPTH);

  // transaction field widths
  localparam int MODE_W = 2;
  localparam int CELL_W = 6;
  localparam int WINF_W = 4;
  localparam int VAL_W  = 32;

  // scan index, window position and row/column offset arithmetic
  localparam int WIN_W  = $clog2(WIN_SIDE);
  localparam int SPAN_W = $clog2((2 ** CELL_W) + WIN_SIDE);

  // configuration registers
  localparam int DIM_W      = 7;
  localparam int RAD_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_WEIGHT = 2'd0,
    MODE_WR_MSG    = 2'd1,
    MODE_QUERY     = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS  = 2'd0,
    CFG_GRID_COLS  = 2'd1,
    CFG_WIN_RADIUS = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [CELL_W-1:0]       cell_row;
    logic [CELL_W-1:0]       cell_col;
    logic [WINF_W-1:0]       win_row;
    logic [WINF_W-1:0]       win_col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] best_value;
    logic [CELL_W-1:0]       best_row;
    logic [CELL_W-1:0]       best_col;
  } out_item_t;

  // one window position on its way through the read pipeline
  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
  } tap_t;

  // running maximum and where it was found
  typedef struct packed {
    logic                    have;
    logic signed [VAL_W-1:0] value;
    logic [CELL_W-1:0]       row;
    logic [CELL_W-1:0]       col;
  } acc_res_t;

endpackage

[sv/wmpa_acc.sv]
// wmpa_acc: saturating add of message and weight, then running max with first-wins argmax
// depends on wmpa_pkg
module wmpa_acc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clear,
  input  wmpa_pkg::tap_t                    tap,
  input  logic signed [wmpa_pkg::VAL_W-1:0] msg_word,
  input  logic signed [wmpa_pkg::VAL_W-1:0] wgt_word,
  output wmpa_pkg::acc_res_t                best
);

  logic signed [wmpa_pkg::VAL_W:0]   sum_wide;
  logic signed [wmpa_pkg::VAL_W-1:0] sum_sat;
  logic signed [wmpa_pkg::VAL_W-1:0] sum_r;
  wmpa_pkg::tap_t                    tap_r;
  wmpa_pkg::acc_res_t                best_r;
  logic                              take;

  // one guard bit catches overflow
  assign sum_wide = {msg_word[wmpa_pkg::VAL_W-1], msg_word}
                  + {wgt_word[wmpa_pkg::VAL_W-1], wgt_word};

  always_comb begin
    if (sum_wide[wmpa_pkg::VAL_W] != sum_wide[wmpa_pkg::VAL_W-1]) begin
      sum_sat = sum_wide[wmpa_pkg::VAL_W] ? wmpa_pkg::VAL_MIN : wmpa_pkg::VAL_MAX;
    end else begin
      sum_sat = sum_wide[wmpa_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_sat;
    if (!rst_n) begin
      tap_r <= '0;
    end else begin
      tap_r <= tap;
    end
  end

  // strict greater keeps the earliest of equal sums
  assign take = tap_r.valid && (!best_r.have || (sum_r > best_r.value));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (clear) begin
      best_r.have <= 1'b0;
    end else if (take) begin
      best_r.have  <= 1'b1;
      best_r.value <= sum_r;
      best_r.row   <= tap_r.row;
      best_r.col   <= tap_r.col;
    end
  end

  assign best = best_r;

endmodule

[sv/windowed_max_plus_argmax.sv]
// windowed_max_plus_argmax: max-sum message step over a 2d grid, top level with both memories
// depends on wmpa_pkg and wmpa_acc
// a query is taken only while idle, and nothing more until its scan, the pipeline drain and
// hand-over to the output register are done; the scan's pace is set by the single message memory read
// port visiting one window position a cycle; weight and message writes are taken only while idle
// reset: synchronous active-low rst_n clears control and configuration (64 x 64 grid, radius 2);
// the memories need no clearing pass and hold whatever was last written
module windowed_max_plus_argmax (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  wmpa_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output wmpa_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wmpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [wmpa_pkg::DIM_W-1:0] grid_rows_r;
  logic [wmpa_pkg::DIM_W-1:0] grid_cols_r;
  logic [wmpa_pkg::RAD_W-1:0] radius_r;
  logic [wmpa_pkg::DIM_W-1:0] rows_eff;
  logic [wmpa_pkg::DIM_W-1:0] cols_eff;
  logic [wmpa_pkg::RAD_W-1:0] rad_eff;
  logic [wmpa_pkg::WIN_W-1:0] win_last;

  // sequencer
  wmpa_pkg::state_t            state_r;
  wmpa_pkg::state_t            state_nxt;
  logic                        in_fire;
  logic                        cell_on_grid;
  logic                        query_go;
  logic                        scan_en;
  logic                        scan_last;
  logic                        out_free;
  logic                        out_load;
  logic [wmpa_pkg::CELL_W-1:0] crow_r;
  logic [wmpa_pkg::CELL_W-1:0] ccol_r;
  logic [wmpa_pkg::WIN_W-1:0]  dr_idx_r;
  logic [wmpa_pkg::WIN_W-1:0]  dc_idx_r;

  // window position to grid position
  logic [wmpa_pkg::SPAN_W-1:0] row_tmp;
  logic [wmpa_pkg::SPAN_W-1:0] col_tmp;
  logic [wmpa_pkg::SPAN_W-1:0] row_off;
  logic [wmpa_pkg::SPAN_W-1:0] col_off;
  logic                        row_ok;
  logic                        col_ok;
  wmpa_pkg::tap_t              tap_s1_r;

  // memories
  logic signed [wmpa_pkg::VAL_W-1:0] msg_mem [wmpa_pkg::MSG_DEPTH];
  logic signed [wmpa_pkg::VAL_W-1:0] wgt_mem [wmpa_pkg::WGT_DEPTH];
  logic signed [wmpa_pkg::VAL_W-1:0] msg_rdata_r;
  logic signed [wmpa_pkg::VAL_W-1:0] wgt_rdata_r;
  logic [wmpa_pkg::MSG_AW-1:0]       msg_raddr;
  logic [wmpa_pkg::WGT_AW-1:0]       wgt_raddr;
  logic [wmpa_pkg::MSG_AW-1:0]       msg_waddr;
  logic [wmpa_pkg::WGT_AW-1:0]       wgt_waddr;
  logic                              msg_we;
  logic                              wgt_we;

  // result
  wmpa_pkg::acc_res_t  acc_best;
  logic                out_valid_r;
  wmpa_pkg::out_item_t out_data_r;

  // ---------------------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= wmpa_pkg::DIM_W'(64);
      grid_cols_r <= wmpa_pkg::DIM_W'(64);
      radius_r    <= wmpa_pkg::RAD_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wmpa_pkg::CFG_GRID_ROWS:  grid_rows_r <= cfg_data[wmpa_pkg::DIM_W-1:0];
        wmpa_pkg::CFG_GRID_COLS:  grid_cols_r <= cfg_data[wmpa_pkg::DIM_W-1:0];
        wmpa_pkg::CFG_WIN_RADIUS: radius_r    <= cfg_data[wmpa_pkg::RAD_W-1:0];
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // sizes above the store limits act as the limits
  assign rows_eff = (grid_rows_r > wmpa_pkg::DIM_W'(wmpa_pkg::MAX_ROWS))
                  ? wmpa_pkg::DIM_W'(wmpa_pkg::MAX_ROWS) : grid_rows_r;
  assign cols_eff = (grid_cols_r > wmpa_pkg::DIM_W'(wmpa_pkg::MAX_COLS))
                  ? wmpa_pkg::DIM_W'(wmpa_pkg::MAX_COLS) : grid_cols_r;
  assign rad_eff  = (radius_r > wmpa_pkg::RAD_W'(wmpa_pkg::MAX_RADIUS))
                  ? wmpa_pkg::RAD_W'(wmpa_pkg::MAX_RADIUS) : radius_r;
  assign win_last = wmpa_pkg::WIN_W'({rad_eff, 1'b0});

  // ---------------------------------------------------------------------------
  // input transaction decode
  // ---------------------------------------------------------------------------
  assign in_fire      = in_valid && in_ready;
  assign cell_on_grid = (wmpa_pkg::DIM_W'(in_data.cell_row) < rows_eff)
                     && (wmpa_pkg::DIM_W'(in_data.cell_col) < cols_eff);
  // a query off the grid is taken and dropped without a result
  assign query_go = in_fire && (in_data.mode == wmpa_pkg::MODE_QUERY) && cell_on_grid;

  // writes land at the accepting edge; no scan is running then, so no hazard
  assign wgt_we = in_fire && (in_data.mode == wmpa_pkg::MODE_WR_WEIGHT)
               && (int'(in_data.win_row) < wmpa_pkg::WIN_SIDE)
               && (int'(in_data.win_col) < wmpa_pkg::WIN_SIDE);
  assign msg_we = in_fire && (in_data.mode == wmpa_pkg::MODE_WR_MSG)
               && (int'(in_data.cell_row) < wmpa_pkg::MAX_ROWS)
               && (int'(in_data.cell_col) < wmpa_pkg::MAX_COLS);

  assign wgt_waddr = wmpa_pkg::WGT_AW'(int'(in_data.win_row) * wmpa_pkg::WIN_SIDE
                                      + int'(in_data.win_col));
  assign msg_waddr = wmpa_pkg::MSG_AW'(int'(in_data.cell_row) * wmpa_pkg::MAX_COLS
                                      + int'(in_data.cell_col));

  // ---------------------------------------------------------------------------
  // sequencer: idle, one window position a cycle, pipeline drain through drain_a and drain_b,
  // then hand over to the output register once it is free
  // ---------------------------------------------------------------------------
  assign scan_last = (dr_idx_r == win_last) && (dc_idx_r == win_last);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wmpa_pkg::ST_IDLE:    if (query_go) state_nxt = wmpa_pkg::ST_SCAN;
      wmpa_pkg::ST_SCAN:    if (scan_last) state_nxt = wmpa_pkg::ST_DRAIN_A;
      wmpa_pkg::ST_DRAIN_A: state_nxt = wmpa_pkg::ST_DRAIN_B;
      wmpa_pkg::ST_DRAIN_B: state_nxt = wmpa_pkg::ST_DONE;
      wmpa_pkg::ST_DONE:    if (out_free) state_nxt = wmpa_pkg::ST_IDLE;
      default:              state_nxt = wmpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    scan_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      wmpa_pkg::ST_IDLE: in_ready = 1'b1;
      wmpa_pkg::ST_SCAN: scan_en  = 1'b1;
      wmpa_pkg::ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // query cell and window indices, dr/dc run 0..2r for offsets -r..r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crow_r   <= '0;
      ccol_r   <= '0;
      dr_idx_r <= '0;
      dc_idx_r <= '0;
    end else if (query_go) begin
      crow_r   <= in_data.cell_row;
      ccol_r   <= in_data.cell_col;
      dr_idx_r <= '0;
      dc_idx_r <= '0;
    end else if (scan_en) begin
      if (dc_idx_r == win_last) begin
        dc_idx_r <= '0;
        dr_idx_r <= dr_idx_r + wmpa_pkg::WIN_W'(1);
      end else begin
        dc_idx_r <= dc_idx_r + wmpa_pkg::WIN_W'(1);
      end
    end
  end

  // neighbour position = cell + idx - r, kept unsigned by testing idx + cell >= r
  assign row_tmp = wmpa_pkg::SPAN_W'(crow_r) + wmpa_pkg::SPAN_W'(dr_idx_r);
  assign col_tmp = wmpa_pkg::SPAN_W'(ccol_r) + wmpa_pkg::SPAN_W'(dc_idx_r);
  assign row_off = row_tmp - wmpa_pkg::SPAN_W'(rad_eff);
  assign col_off = col_tmp - wmpa_pkg::SPAN_W'(rad_eff);
  assign row_ok  = (row_tmp >= wmpa_pkg::SPAN_W'(rad_eff))
                && (row_off < wmpa_pkg::SPAN_W'(rows_eff));
  assign col_ok  = (col_tmp >= wmpa_pkg::SPAN_W'(rad_eff))
                && (col_off < wmpa_pkg::SPAN_W'(cols_eff));

  // off-grid positions still read, but travel with valid low
  assign msg_raddr = wmpa_pkg::MSG_AW'(int'(row_off[wmpa_pkg::CELL_W-1:0]) * wmpa_pkg::MAX_COLS
                                      + int'(col_off[wmpa_pkg::CELL_W-1:0]));
  assign wgt_raddr = wmpa_pkg::WGT_AW'(int'(dr_idx_r) * wmpa_pkg::WIN_SIDE + int'(dc_idx_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_s1_r <= '0;
    end else begin
      tap_s1_r.valid <= scan_en && row_ok && col_ok;
      tap_s1_r.row   <= row_off[wmpa_pkg::CELL_W-1:0];
      tap_s1_r.col   <= col_off[wmpa_pkg::CELL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // memories: one write port fed by input transactions, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_waddr] <= in_data.value;
    end
    msg_rdata_r <= msg_mem[msg_raddr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= in_data.value;
    end
    wgt_rdata_r <= wgt_mem[wgt_raddr];
  end

  // ---------------------------------------------------------------------------
  // saturating sum and running max, two stages behind the read
  // ---------------------------------------------------------------------------
  wmpa_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (query_go),
    .tap      (tap_s1_r),
    .msg_word (msg_rdata_r),
    .wgt_word (wgt_rdata_r),
    .best     (acc_best)
  );

  // ---------------------------------------------------------------------------
  // output register: holds a result while the next transaction is taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.best_value <= acc_best.value;
      out_data_r.best_row   <= acc_best.row;
      out_data_r.best_col   <= acc_best.col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the query cell is always on the grid, so a finished scan always found something
  a_have_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmpa_pkg::ST_DONE) |-> acc_best.have)
    else $error("scan finished without any on-grid neighbour");

  // the winning neighbour lies inside the grid in use
  a_best_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmpa_pkg::ST_DONE) |->
      (wmpa_pkg::DIM_W'(acc_best.row) < rows_eff) && (wmpa_pkg::DIM_W'(acc_best.col) < cols_eff))
    else $error("argmax position outside the grid");

  // window indices never leave the square
  a_idx_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wmpa_pkg::ST_SCAN) |-> (dr_idx_r <= win_last) && (dc_idx_r <= win_last))
    else $error("window index past the window edge");

  // a result handed over shows up at the port on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid)
    else $error("loaded result not presented");

  // no memory write while a scan is in flight
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != wmpa_pkg::ST_IDLE) |-> !(msg_we || wgt_we))
    else $error("memory write during a scan");

endmodule

[sim/windowed_max_plus_argmax_test.sv]
// self-checking testbench for windowed_max_plus_argmax: weight, message and query transactions
// against an in-bench max-sum predictor, across several grid and radius settings
// depends on wmpa_pkg and the windowed_max_plus_argmax rtl
module windowed_max_plus_argmax_test;
  import wmpa_pkg::*;

  // codes the package leaves unnamed
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  // the longest query scans the full window at MAX_RADIUS; settle past it with a margin
  localparam int SETTLE_CYCLES   = WIN_SIDE * WIN_SIDE + 16;
  localparam int HOLD_OFF_CYCLES = 700;
  localparam int DRAIN_CAP       = 300000;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int NUM_PHASES      = 11;
  localparam int SQUEEZE_PHASE   = 7;
  localparam int CALM_PHASE      = 8;
  localparam int ALIAS_PHASE     = 1;

  // random phases: rows, cols, radius and transaction budget
  // zero rows is the empty grid, 100 and 127 sit above the grid maximum
  int ph_rows   [NUM_PHASES] = '{8, 1, 64, 0, 100, 5, 64, 16, 12, 2, 64};
  int ph_cols   [NUM_PHASES] = '{8, 1, 64, 5, 127, 64, 3, 16, 9, 40, 64};
  int ph_rad    [NUM_PHASES] = '{2, 0, 7, 3, 4, 7, 5, 3, 6, 1, 2};
  int ph_budget [NUM_PHASES] = '{230, 120, 260, 50, 200, 160, 160, 200, 180, 150, 140};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the block: configuration and both stores
  logic [DIM_W-1:0]        cfg_rows = 7'd64;
  logic [DIM_W-1:0]        cfg_cols = 7'd64;
  logic [RAD_W-1:0]        cfg_radius = 3'd2;
  logic signed [VAL_W-1:0] prior_msg [MSG_DEPTH];
  logic signed [VAL_W-1:0] pair_weight [WGT_DEPTH];

  // which entries the stimulus has written so far, so a query never reads an unwritten one
  bit msg_loaded [MSG_DEPTH];
  bit wgt_loaded [WGT_DEPTH];

  in_item_t  item_backlog [$];
  out_item_t best_expected [$];

  logic calm = 1'b0;
  int   squeeze_req = 0;
  int   squeeze_seen = 0;
  int   hold_left = 0;

  int queued_total = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int fail_count = 0;
  int cycle_count = 0;

  windowed_max_plus_argmax i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // grid size register clamped to the store dimension
  function automatic int grid_extent(logic [DIM_W-1:0] d, int cap);
    return (int'(d) > cap) ? cap : int'(d);
  endfunction

  function automatic int radius_in_use();
    return (int'(cfg_radius) > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_radius);
  endfunction

  // one max-sum step: stores update on writes, a query on the grid gives one result
  function automatic void max_sum_step(in_item_t it);
    int rows, cols, rad, row0, col0, r, c, dr, dc, bi, bj;
    longint sum, best;
    bit have;
    out_item_t res;
    if (it.mode == MODE_WR_WEIGHT) begin
      if (int'(it.win_row) < WIN_SIDE && int'(it.win_col) < WIN_SIDE)
        pair_weight[int'(it.win_row) * WIN_SIDE + int'(it.win_col)] = it.value;
    end else if (it.mode == MODE_WR_MSG) begin
      prior_msg[int'(it.cell_row) * MAX_COLS + int'(it.cell_col)] = it.value;
    end else if (it.mode == MODE_QUERY) begin
      rows = grid_extent(cfg_rows, MAX_ROWS);
      cols = grid_extent(cfg_cols, MAX_COLS);
      rad  = radius_in_use();
      row0 = int'(it.cell_row);
      col0 = int'(it.cell_col);
      // a query off the grid gives nothing
      if (row0 < rows && col0 < cols) begin
        have = 1'b0;
        best = 0;
        bi = row0;
        bj = col0;
        for (dr = -rad; dr <= rad; dr++) begin
          r = row0 + dr;
          if (r >= 0 && r < rows) begin
            for (dc = -rad; dc <= rad; dc++) begin
              c = col0 + dc;
              if (c >= 0 && c < cols) begin
                sum = longint'(prior_msg[r * MAX_COLS + c])
                    + longint'(pair_weight[(dr + rad) * WIN_SIDE + (dc + rad)]);
                if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
                if (sum < longint'(VAL_MIN)) sum = longint'(VAL_MIN);
                // strict compare, so a tie keeps the earlier position
                if (!have || sum > best) begin
                  have = 1'b1;
                  best = sum;
                  bi = r;
                  bj = c;
                end
              end
            end
          end
        end
        res.best_value = best[VAL_W-1:0];
        res.best_row   = CELL_W'(bi);
        res.best_col   = CELL_W'(bj);
        best_expected.push_back(res);
      end
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    int k;
    k = $urandom_range(6);
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return VAL_MAX - $urandom_range(3);
      3: return VAL_MIN + $urandom_range(3);
      // small whole numbers in q16.16 make ties common
      4, 5, 6: return (k - 3) * 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [MODE_W-1:0] mode, int row, int col,
                                         int wr, int wc, logic signed [VAL_W-1:0] v);
    in_item_t it;
    it.mode     = mode;
    it.cell_row = CELL_W'(row);
    it.cell_col = CELL_W'(col);
    it.win_row  = WINF_W'(wr);
    it.win_col  = WINF_W'(wc);
    it.value    = v;
    return it;
  endfunction

  task automatic queue_item(in_item_t it);
    if (it.mode == MODE_WR_WEIGHT && int'(it.win_row) < WIN_SIDE && int'(it.win_col) < WIN_SIDE)
      wgt_loaded[int'(it.win_row) * WIN_SIDE + int'(it.win_col)] = 1'b1;
    if (it.mode == MODE_WR_MSG)
      msg_loaded[int'(it.cell_row) * MAX_COLS + int'(it.cell_col)] = 1'b1;
    item_backlog.push_back(it);
    queued_total++;
  endtask

  // query one cell, first writing any window entry the block has never seen
  task automatic queue_query(int row, int col);
    int rows, cols, rad, r, c, dr, dc, widx;
    rows = grid_extent(cfg_rows, MAX_ROWS);
    cols = grid_extent(cfg_cols, MAX_COLS);
    rad  = radius_in_use();
    if (row < rows && col < cols) begin
      for (dr = -rad; dr <= rad; dr++) begin
        for (dc = -rad; dc <= rad; dc++) begin
          r = row + dr;
          c = col + dc;
          if (r >= 0 && r < rows && c >= 0 && c < cols) begin
            if (!msg_loaded[r * MAX_COLS + c])
              queue_item(make_item(MODE_WR_MSG, r, c, $urandom_range(15),
                                   $urandom_range(15), rand_value()));
            widx = (dr + rad) * WIN_SIDE + (dc + rad);
            if (!wgt_loaded[widx])
              queue_item(make_item(MODE_WR_WEIGHT, $urandom_range(63), $urandom_range(63),
                                   dr + rad, dc + rad, rand_value()));
          end
        end
      end
    end
    queue_item(make_item(MODE_QUERY, row, col, $urandom_range(15), $urandom_range(15),
                         $urandom));
  endtask

  // mostly near a small hot area so a large grid does not need a full load
  function automatic int pick_cell(int n, int hot);
    case ($urandom_range(19))
      0: return 0;
      1: return n - 1;
      default: return hot + $urandom_range(((n < 8) ? n : 8) - 1);
    endcase
  endfunction

  task automatic fill_random(int budget);
    int stop, rows, cols, hot_r, hot_c, pick, row, col;
    rows  = grid_extent(cfg_rows, MAX_ROWS);
    cols  = grid_extent(cfg_cols, MAX_COLS);
    hot_r = (rows > 8) ? $urandom_range(rows - 8) : 0;
    hot_c = (cols > 8) ? $urandom_range(cols - 8) : 0;
    stop  = queued_total + budget;
    while (queued_total < stop) begin
      pick = $urandom_range(99);
      if (pick < 50 && rows > 0 && cols > 0) begin
        queue_query(pick_cell(rows, hot_r), pick_cell(cols, hot_c));
      end else if (pick < 58) begin
        // off the grid where the grid leaves room, else a corner
        if (rows < MAX_ROWS) begin
          row = $urandom_range(MAX_ROWS - 1, rows);
          col = $urandom_range(MAX_COLS - 1);
        end else if (cols < MAX_COLS) begin
          row = $urandom_range(MAX_ROWS - 1);
          col = $urandom_range(MAX_COLS - 1, cols);
        end else begin
          row = $urandom_range(1) ? MAX_ROWS - 1 : 0;
          col = $urandom_range(1) ? MAX_COLS - 1 : 0;
        end
        queue_query(row, col);
      end else if (pick < 76) begin
        if (rows > 0 && cols > 0 && $urandom_range(1)) begin
          row = pick_cell(rows, hot_r);
          col = pick_cell(cols, hot_c);
        end else begin
          row = $urandom_range(MAX_ROWS - 1);
          col = $urandom_range(MAX_COLS - 1);
        end
        queue_item(make_item(MODE_WR_MSG, row, col, $urandom_range(15), $urandom_range(15),
                             rand_value()));
      end else if (pick < 92) begin
        // positions 15 lie outside the table and must be dropped
        queue_item(make_item(MODE_WR_WEIGHT, $urandom_range(63), $urandom_range(63),
                             $urandom_range(15), $urandom_range(15), rand_value()));
      end else begin
        queue_item(make_item(MODE_UNUSED, $urandom_range(63), $urandom_range(63),
                             $urandom_range(15), $urandom_range(15), $urandom));
      end
    end
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GRID_ROWS:  cfg_rows = data;
      CFG_GRID_COLS:  cfg_cols = data;
      CFG_WIN_RADIUS: cfg_radius = data[RAD_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // spare upper bits of the radius write carry random junk
  task automatic set_grid(int rows, int cols, int rad);
    write_reg(CFG_GRID_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_GRID_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_WIN_RADIUS, {4'($urandom), 3'(rad)});
  endtask

  // wait for every queued transaction and result, then for the block to go quiet
  task automatic drain_block();
    int waited;
    waited = 0;
    while ((item_backlog.size() != 0 || in_valid || best_expected.size() != 0)
           && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    if (best_expected.size() != 0) begin
      $display("error: %0d expected results never arrived", best_expected.size());
      fail_count++;
      best_expected.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: takes the next pending transaction when the slot frees, with random gaps outside the calm phase
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        max_sum_step(in_data);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (item_backlog.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
          in_data  <= item_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready: random stalls outside the calm phase, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (squeeze_seen != squeeze_req) begin
      squeeze_seen <= squeeze_req;
      hold_left    <= HOLD_OFF_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (best_expected.size() == 0) begin
        fail_count++;
        mismatches++;
        if (mismatches <= 10)
          $display("error: unexpected result value %h row %0d col %0d",
                   out_data.best_value, out_data.best_row, out_data.best_col);
      end else begin
        want = best_expected.pop_front();
        results_checked++;
        if (out_data.best_value !== want.best_value || out_data.best_row !== want.best_row
            || out_data.best_col !== want.best_col) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10)
            $display("error: result %0d expected %h (%0d,%0d) got %h (%0d,%0d)",
                     results_checked, want.best_value, want.best_row, want.best_col,
                     out_data.best_value, out_data.best_row, out_data.best_col);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               best_expected.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int i, j, k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, radius 0: low then high saturation at two corners
    set_grid(64, 64, 0);
    queue_item(make_item(MODE_WR_WEIGHT, 0, 0, 0, 0, VAL_MIN));
    queue_item(make_item(MODE_WR_MSG, 63, 0, 0, 0, VAL_MIN));
    queue_item(make_item(MODE_QUERY, 63, 0, 15, 15, VAL_MIN));
    queue_item(make_item(MODE_WR_WEIGHT, 0, 0, 0, 0, VAL_MAX));
    queue_item(make_item(MODE_WR_MSG, 0, 63, 0, 0, VAL_MAX));
    queue_item(make_item(MODE_QUERY, 0, 63, 0, 0, VAL_MAX));
    drain_block();

    // directed, radius 1: zero weights but for two extremes, dropped writes, a tie
    set_grid(64, 64, 1);
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        queue_item(make_item(MODE_WR_WEIGHT, 0, 0, i, j,
                             (i == 2 && j == 2) ? VAL_MAX : (i == 0 && j == 2) ? VAL_MIN : 0));
    queue_item(make_item(MODE_WR_WEIGHT, 63, 63, 14, 14, rand_value()));
    queue_item(make_item(MODE_WR_WEIGHT, 0, 0, 15, 7, VAL_MAX));
    queue_item(make_item(MODE_WR_WEIGHT, 0, 0, 3, 15, VAL_MAX));
    // four equal sums at the bottom-right corner, the first scanned must win
    queue_item(make_item(MODE_WR_MSG, 62, 62, 0, 0, 3 * 65536));
    queue_item(make_item(MODE_WR_MSG, 62, 63, 0, 0, 3 * 65536));
    queue_item(make_item(MODE_WR_MSG, 63, 62, 0, 0, 3 * 65536));
    queue_item(make_item(MODE_WR_MSG, 63, 63, 0, 0, 3 * 65536));
    queue_item(make_item(MODE_QUERY, 63, 63, 15, 0, 0));
    queue_query(0, 0);
    queue_item(make_item(MODE_UNUSED, 63, 63, 15, 15, -1));
    drain_block();

    for (k = 0; k < NUM_PHASES; k++) begin
      set_grid(ph_rows[k], ph_cols[k], ph_rad[k]);
      // the spare register index must not disturb the real ones
      if (k == ALIAS_PHASE)
        write_reg(CFG_UNUSED, 7'h7f);
      calm <= (k == CALM_PHASE);
      fill_random(ph_budget[k]);
      if (k == SQUEEZE_PHASE)
        squeeze_req <= squeeze_req + 1;
      drain_block();
    end

    $display("covered %0d input transactions under %0d grid settings, %0d register writes",
             items_sent, NUM_PHASES + 2, cfg_writes);
    $display("checked %0d max-sum results, %0d mismatches", results_checked, mismatches);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
